// ----- rtl/core/pps_pkg.sv -----
// Shared types and constants for the pick-and-place sequencer.
// No dependencies; used by pps_joint and pick_place_sequencer_core.
`default_nettype none

package pps_pkg;

  localparam int ANGLE_BITS_DEF = 16;
  localparam int GOAL_W         = 16;
  localparam int DIST_W         = 12;
  localparam int TOL_W          = 15;
  localparam int DWELL_W        = 8;
  localparam int LIMIT_W        = 15;
  localparam int GAIN_W         = 4;
  localparam int ADDR_W         = 5;
  localparam int DATA_W         = 32;

  typedef enum logic [2:0] {
    PH_WAIT    = 3'd0,
    PH_GRASP   = 3'd1,
    PH_ROTATE  = 3'd2,
    PH_RELEASE = 3'd3,
    PH_RETURN  = 3'd4
  } phase_t;

  typedef enum logic [1:0] {
    GRIP_NONE  = 2'd0,
    GRIP_CLOSE = 2'd1,
    GRIP_OPEN  = 2'd2
  } grip_t;

  // register index = paddr[4:2]
  localparam logic [2:0] REG_DETECT = 3'd0;
  localparam logic [2:0] REG_TOL    = 3'd1;
  localparam logic [2:0] REG_DWELL  = 3'd2;
  localparam logic [2:0] REG_LIM_A  = 3'd3;
  localparam logic [2:0] REG_LIM_B  = 3'd4;
  localparam logic [2:0] REG_LIM_C  = 3'd5;
  localparam logic [2:0] REG_LIM_D  = 3'd6;

  localparam logic [DIST_W-1:0]  DETECT_RST = 12'd500;
  localparam logic [TOL_W-1:0]   TOL_RST    = 15'd205;
  localparam logic [DWELL_W-1:0] DWELL_RST  = 8'd8;
  localparam logic [LIMIT_W-1:0] LIMIT_RST  = 15'd12868;

  // place pose, Q4.12 rounded to nearest
  localparam logic signed [GOAL_W-1:0] PLACE_A = -16'sd7700;
  localparam logic signed [GOAL_W-1:0] PLACE_B = -16'sd8765;
  localparam logic signed [GOAL_W-1:0] PLACE_C = -16'sd9748;
  localparam logic signed [GOAL_W-1:0] PLACE_D = -16'sd6185;

  localparam logic [GAIN_W-1:0] GAIN_A = 4'd10;
  localparam logic [GAIN_W-1:0] GAIN_B = 4'd9;
  localparam logic [GAIN_W-1:0] GAIN_C = 4'd8;
  localparam logic [GAIN_W-1:0] GAIN_D = 4'd7;

endpackage

`default_nettype wire

// ----- rtl/core/pick_place_sequencer_core.sv -----
// Pick-and-place sequencer top level: input register, phase logic, result register.
// Depends on pps_pkg and pps_joint.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+------------------------------------------
//  in      | in        | in_valid / in_stall  | distance, angle_a..angle_d
//  out     | out       | out_valid / out_stall| phase, drive_valid, goal_select,
//          |           |                      | vel_a..vel_d, gripper_cmd
//  config  | in        | APB psel/penable     | seven registers at 4*i
//
// One item per cycle sustained while out_stall is low; each item passes the input register, then the result register.
// The phase and dwell counter update as an item moves into the result register.
// Synchronous active-high rst clears valids, phase and dwell counter and loads register defaults.
// in_stall rises only while the input register holds an item that cannot advance.
`default_nettype none

module pick_place_sequencer_core #(
  parameter int ANGLE_BITS = pps_pkg::ANGLE_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  // input channel
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic        [pps_pkg::DIST_W-1:0]   distance,
  input  logic signed [ANGLE_BITS-1:0]        angle_a,
  input  logic signed [ANGLE_BITS-1:0]        angle_b,
  input  logic signed [ANGLE_BITS-1:0]        angle_c,
  input  logic signed [ANGLE_BITS-1:0]        angle_d,
  // output channel
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic        [2:0]                   phase,
  output logic                                drive_valid,
  output logic                                goal_select,
  output logic signed [ANGLE_BITS-1:0]        vel_a,
  output logic signed [ANGLE_BITS-1:0]        vel_b,
  output logic signed [ANGLE_BITS-1:0]        vel_c,
  output logic signed [ANGLE_BITS-1:0]        vel_d,
  output logic        [1:0]                   gripper_cmd,
  // configuration
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic        [pps_pkg::ADDR_W-1:0]   paddr,
  input  logic        [pps_pkg::DATA_W-1:0]   pwdata,
  output logic        [pps_pkg::DATA_W-1:0]   prdata,
  output logic                                pready
);

  localparam int EW = ((ANGLE_BITS > pps_pkg::GOAL_W) ? ANGLE_BITS : pps_pkg::GOAL_W) + 1;

  // configuration registers
  logic [pps_pkg::DIST_W-1:0]  detect_threshold;
  logic [pps_pkg::TOL_W-1:0]   arrive_tolerance;
  logic [pps_pkg::DWELL_W-1:0] dwell_ticks;
  logic [pps_pkg::LIMIT_W-1:0] speed_limit_a;
  logic [pps_pkg::LIMIT_W-1:0] speed_limit_b;
  logic [pps_pkg::LIMIT_W-1:0] speed_limit_c;
  logic [pps_pkg::LIMIT_W-1:0] speed_limit_d;

  logic       cfg_wr;
  logic [2:0] cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = paddr[4:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      detect_threshold <= pps_pkg::DETECT_RST;
      arrive_tolerance <= pps_pkg::TOL_RST;
      dwell_ticks      <= pps_pkg::DWELL_RST;
      speed_limit_a    <= pps_pkg::LIMIT_RST;
      speed_limit_b    <= pps_pkg::LIMIT_RST;
      speed_limit_c    <= pps_pkg::LIMIT_RST;
      speed_limit_d    <= pps_pkg::LIMIT_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        pps_pkg::REG_DETECT: detect_threshold <= pwdata[pps_pkg::DIST_W-1:0];
        pps_pkg::REG_TOL:    arrive_tolerance <= pwdata[pps_pkg::TOL_W-1:0];
        pps_pkg::REG_DWELL:  dwell_ticks      <= pwdata[pps_pkg::DWELL_W-1:0];
        pps_pkg::REG_LIM_A:  speed_limit_a    <= pwdata[pps_pkg::LIMIT_W-1:0];
        pps_pkg::REG_LIM_B:  speed_limit_b    <= pwdata[pps_pkg::LIMIT_W-1:0];
        pps_pkg::REG_LIM_C:  speed_limit_c    <= pwdata[pps_pkg::LIMIT_W-1:0];
        pps_pkg::REG_LIM_D:  speed_limit_d    <= pwdata[pps_pkg::LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      pps_pkg::REG_DETECT: prdata = pps_pkg::DATA_W'(detect_threshold);
      pps_pkg::REG_TOL:    prdata = pps_pkg::DATA_W'(arrive_tolerance);
      pps_pkg::REG_DWELL:  prdata = pps_pkg::DATA_W'(dwell_ticks);
      pps_pkg::REG_LIM_A:  prdata = pps_pkg::DATA_W'(speed_limit_a);
      pps_pkg::REG_LIM_B:  prdata = pps_pkg::DATA_W'(speed_limit_b);
      pps_pkg::REG_LIM_C:  prdata = pps_pkg::DATA_W'(speed_limit_c);
      pps_pkg::REG_LIM_D:  prdata = pps_pkg::DATA_W'(speed_limit_d);
      default:             prdata = '0;
    endcase
  end

  // input register
  logic                         in_q_valid;
  logic [pps_pkg::DIST_W-1:0]   dist_q;
  logic signed [ANGLE_BITS-1:0] ang_a_q;
  logic signed [ANGLE_BITS-1:0] ang_b_q;
  logic signed [ANGLE_BITS-1:0] ang_c_q;
  logic signed [ANGLE_BITS-1:0] ang_d_q;

  logic out_free;
  logic advance;
  logic take;

  assign out_free = !out_valid || !out_stall;
  assign advance  = in_q_valid && out_free;
  assign in_stall = in_q_valid && !out_free;
  assign take     = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (take) begin
      in_q_valid <= 1'b1;
    end else if (advance) begin
      in_q_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      dist_q  <= distance;
      ang_a_q <= angle_a;
      ang_b_q <= angle_b;
      ang_c_q <= angle_c;
      ang_d_q <= angle_d;
    end
  end

  // sequencer state
  pps_pkg::phase_t              phase_reg;
  pps_pkg::phase_t              phase_reg_next;
  logic [pps_pkg::DWELL_W-1:0]  dwell_count;
  logic [pps_pkg::DWELL_W-1:0]  dwell_count_next;
  logic [pps_pkg::DWELL_W-1:0]  dwell_loaded;

  logic                         detect;
  logic                         arrived;
  logic                         load_dwell;
  logic                         drive;
  logic                         home;
  pps_pkg::grip_t               grip;

  // joint c arrival against the goal of the current phase
  logic signed [pps_pkg::GOAL_W-1:0] goal_c;
  logic signed [EW-1:0]              diff_c;
  logic signed [EW-1:0]              mag_c;

  assign goal_c  = home ? '0 : pps_pkg::PLACE_C;
  assign diff_c  = EW'(ang_c_q) - EW'(goal_c);
  assign mag_c   = (diff_c < 0) ? -diff_c : diff_c;
  assign arrived = $unsigned(mag_c) < EW'(arrive_tolerance);
  assign detect  = dist_q < detect_threshold;

  // next phase
  always_comb begin
    phase_reg_next = phase_reg;
    load_dwell     = 1'b0;
    case (phase_reg)
      pps_pkg::PH_WAIT: begin
        if (detect) begin
          phase_reg_next = pps_pkg::PH_GRASP;
          load_dwell     = 1'b1;
        end
      end
      pps_pkg::PH_GRASP: begin
        if (dwell_count == '0) phase_reg_next = pps_pkg::PH_ROTATE;
      end
      pps_pkg::PH_ROTATE: begin
        if (arrived) begin
          phase_reg_next = pps_pkg::PH_RELEASE;
          load_dwell     = 1'b1;
        end
      end
      pps_pkg::PH_RELEASE: begin
        if (dwell_count == '0) phase_reg_next = pps_pkg::PH_RETURN;
      end
      pps_pkg::PH_RETURN: begin
        if (arrived) phase_reg_next = pps_pkg::PH_WAIT;
      end
      default: phase_reg_next = pps_pkg::PH_WAIT;
    endcase
  end

  // per-phase outputs
  always_comb begin
    drive = 1'b0;
    home  = 1'b0;
    grip  = pps_pkg::GRIP_NONE;
    case (phase_reg)
      pps_pkg::PH_WAIT: begin
        if (detect) grip = pps_pkg::GRIP_CLOSE;
      end
      pps_pkg::PH_ROTATE: begin
        drive = 1'b1;
      end
      pps_pkg::PH_RELEASE: begin
        if (dwell_count == '0) grip = pps_pkg::GRIP_OPEN;
      end
      pps_pkg::PH_RETURN: begin
        drive = 1'b1;
        home  = 1'b1;
      end
      default: ;
    endcase
  end

  // decrement every item, saturating at zero, after any load
  assign dwell_loaded     = load_dwell ? dwell_ticks : dwell_count;
  assign dwell_count_next = (dwell_loaded == '0) ? '0 : dwell_loaded - 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_reg   <= pps_pkg::PH_WAIT;
      dwell_count <= '0;
    end else if (advance) begin
      phase_reg   <= phase_reg_next;
      dwell_count <= dwell_count_next;
    end
  end

  // joint drives
  logic signed [ANGLE_BITS-1:0] vel_a_c;
  logic signed [ANGLE_BITS-1:0] vel_b_c;
  logic signed [ANGLE_BITS-1:0] vel_c_c;
  logic signed [ANGLE_BITS-1:0] vel_d_c;

  pps_joint #(.ANGLE_BITS(ANGLE_BITS), .GAIN(pps_pkg::GAIN_A)) u_joint_a (
    .goal (home ? '0 : pps_pkg::PLACE_A),
    .angle(ang_a_q),
    .limit(speed_limit_a),
    .vel  (vel_a_c)
  );

  pps_joint #(.ANGLE_BITS(ANGLE_BITS), .GAIN(pps_pkg::GAIN_B)) u_joint_b (
    .goal (home ? '0 : pps_pkg::PLACE_B),
    .angle(ang_b_q),
    .limit(speed_limit_b),
    .vel  (vel_b_c)
  );

  pps_joint #(.ANGLE_BITS(ANGLE_BITS), .GAIN(pps_pkg::GAIN_C)) u_joint_c (
    .goal (goal_c),
    .angle(ang_c_q),
    .limit(speed_limit_c),
    .vel  (vel_c_c)
  );

  pps_joint #(.ANGLE_BITS(ANGLE_BITS), .GAIN(pps_pkg::GAIN_D)) u_joint_d (
    .goal (home ? '0 : pps_pkg::PLACE_D),
    .angle(ang_d_q),
    .limit(speed_limit_d),
    .vel  (vel_d_c)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      phase       <= phase_reg;
      drive_valid <= drive;
      goal_select <= home;
      vel_a       <= drive ? vel_a_c : '0;
      vel_b       <= drive ? vel_b_c : '0;
      vel_c       <= drive ? vel_c_c : '0;
      vel_d       <= drive ? vel_d_c : '0;
      gripper_cmd <= grip;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/pps_joint.sv -----
// One joint's velocity command: gain times position error, clamped.
// Depends on pps_pkg for field widths.
`default_nettype none

module pps_joint #(
  parameter int ANGLE_BITS = pps_pkg::ANGLE_BITS_DEF,
  parameter logic [pps_pkg::GAIN_W-1:0] GAIN = pps_pkg::GAIN_A
) (
  input  logic signed [pps_pkg::GOAL_W-1:0]  goal,
  input  logic signed [ANGLE_BITS-1:0]       angle,
  input  logic        [pps_pkg::LIMIT_W-1:0] limit,
  output logic signed [ANGLE_BITS-1:0]       vel
);

  localparam int EW = ((ANGLE_BITS > pps_pkg::GOAL_W) ? ANGLE_BITS : pps_pkg::GOAL_W) + 1;
  localparam int PW = EW + pps_pkg::GAIN_W + 1;
  localparam longint SMAX_L = (longint'(1) << (ANGLE_BITS - 1)) - 1;
  localparam logic signed [PW-1:0] SMAX = PW'(SMAX_L);
  localparam logic signed [PW-1:0] SMIN = -SMAX - PW'(1);

  logic signed [EW-1:0] err;
  logic signed [PW-1:0] prod;
  logic signed [PW-1:0] lim_pos;
  logic signed [PW-1:0] lim_neg;
  logic signed [PW-1:0] u_lim;
  logic signed [PW-1:0] u_sat;

  assign err     = EW'(goal) - EW'(angle);
  assign prod    = PW'(err) * PW'($signed({1'b0, GAIN}));
  assign lim_pos = $signed(PW'(limit));
  assign lim_neg = -lim_pos;

  // speed limit first, then the signed range of the angle word
  always_comb begin
    u_lim = prod;
    if (u_lim > lim_pos) u_lim = lim_pos;
    if (u_lim < lim_neg) u_lim = lim_neg;
    u_sat = u_lim;
    if (u_sat > SMAX) u_sat = SMAX;
    if (u_sat < SMIN) u_sat = SMIN;
  end

  assign vel = u_sat[ANGLE_BITS-1:0];

endmodule

`default_nettype wire
